/* hdl/bcdec_pkg.sv */
// Package for the BC1/BC2/BC3 block decoder: format codes, register map,
// reciprocal constants and the per-pixel context passed to the pixel pipeline.
// No dependencies.
package bcdec_pkg;

  // block_format codes; code 3 decodes like DXT1
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // Register map: index is paddr[2]
  localparam logic REG_BLOCK_FORMAT = 1'b0;

  // Color palette index codes
  localparam logic [1:0] CI_END0 = 2'd0;
  localparam logic [1:0] CI_END1 = 2'd1;
  localparam logic [1:0] CI_MIX2 = 2'd2;
  localparam logic [1:0] CI_MIX3 = 2'd3;

  // Alpha palette index codes with special meaning
  localparam logic [2:0] AI_END0 = 3'd0;
  localparam logic [2:0] AI_END1 = 3'd1;
  localparam logic [2:0] AI_ZERO = 3'd6;
  localparam logic [2:0] AI_FULL = 3'd7;

  // Division by reciprocal: x/3 = (x*683)>>11 for x < 2048,
  // x/7 = (x*2341)>>14 for x < 5461, x/5 = (x*3277)>>14 for x < 16384
  localparam logic [9:0]  RECIP3  = 10'd683;
  localparam int          SHIFT3  = 11;
  localparam logic [11:0] RECIP7  = 12'd2341;
  localparam logic [11:0] RECIP5  = 12'd3277;
  localparam int          SHIFT57 = 14;

  // Everything one pixel needs, picked out of the held block
  typedef struct packed {
    logic [2:0][7:0] c0;     // endpoint 0, widened, {b,g,r}
    logic [2:0][7:0] c1;     // endpoint 1, widened
    logic [1:0]      ci;     // color index
    logic            three;  // DXT1 three-colour mode
    logic            dxt3;
    logic            dxt5;
    logic [7:0]      a0;
    logic [7:0]      a1;
    logic [2:0]      aidx;   // DXT5 alpha index
    logic [3:0]      anib;   // DXT3 explicit alpha
    logic [3:0]      k;      // pixel number
  } pix_t;

endpackage

/* hdl/bcdec_pixel_pipe.sv */
// Four-stage pixel pipeline of the block decoder: numerators, reciprocal
// multiply, palette select and output register.
// Depends on bcdec_pkg.
module bcdec_pixel_pipe import bcdec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pix_valid_i,
  input  pix_t       pix_i,
  output logic       adv_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic [1:0] pixel_column_o,
  output logic [1:0] pixel_row_o,
  output logic       last_pixel_o
);

  logic adv;
  assign adv   = !out_valid_o || out_ready_i;
  assign adv_o = adv;

  // Stage 1: captured pixel context
  logic s1_v_q;
  pix_t s1_q;

  // Stage 2: numerators
  logic            s2_v_q;
  pix_t            s2_q;
  logic            s2_eight_q;
  logic [2:0][7:0] s2_mean_q;
  logic [2:0][9:0] s2_numc_q;
  logic [10:0]     s2_numa_q;

  // Stage 3: quotients
  logic            s3_v_q;
  pix_t            s3_q;
  logic            s3_eight_q;
  logic [2:0][7:0] s3_mean_q;
  logic [2:0][7:0] s3_qc_q;
  logic [7:0]      s3_qa_q;

  // Stage 2 combinational
  logic            eight_d;
  logic [2:0][7:0] mean_d;
  logic [2:0][9:0] numc_d;
  logic [10:0]     numa_d;
  logic [2:0]      wi;
  logic [2:0]      w0;
  logic [8:0]      sum9;

  always_comb begin
    eight_d = s1_q.a0 > s1_q.a1;
    wi      = s1_q.aidx - 3'd1;
    w0      = eight_d ? (3'd7 - wi) : (3'd5 - wi);
    numa_d  = 11'(w0) * 11'(s1_q.a0) + 11'(wi) * 11'(s1_q.a1);
    for (int ch = 0; ch < 3; ch++) begin
      sum9       = 9'(s1_q.c0[ch]) + 9'(s1_q.c1[ch]);
      mean_d[ch] = sum9[8:1];
      if (s1_q.ci == CI_MIX2) begin
        numc_d[ch] = {1'b0, s1_q.c0[ch], 1'b0} + 10'(s1_q.c1[ch]);
      end else begin
        numc_d[ch] = 10'(s1_q.c0[ch]) + {1'b0, s1_q.c1[ch], 1'b0};
      end
    end
  end

  // Stage 3 combinational: divide by 3, 7 or 5 through reciprocals
  logic [2:0][19:0] prodc;
  logic [22:0]      proda;
  logic [2:0][7:0]  qc_d;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prodc[ch] = 20'(s2_numc_q[ch]) * 20'(RECIP3);
      qc_d[ch]  = prodc[ch][SHIFT3 +: 8];
    end
    proda = 23'(s2_numa_q) * 23'(s2_eight_q ? RECIP7 : RECIP5);
  end

  // Stage 4 combinational: palette select
  logic [2:0][7:0] col_d;
  logic [7:0]      alpha_d;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      case (s3_q.ci)
        CI_END0: col_d[ch] = s3_q.c0[ch];
        CI_END1: col_d[ch] = s3_q.c1[ch];
        CI_MIX2: col_d[ch] = s3_q.three ? s3_mean_q[ch] : s3_qc_q[ch];
        default: col_d[ch] = s3_q.three ? 8'd0 : s3_qc_q[ch];
      endcase
    end
    if (s3_q.dxt3) begin
      alpha_d = {s3_q.anib, s3_q.anib};
    end else if (s3_q.dxt5) begin
      if (s3_q.aidx == AI_END0) begin
        alpha_d = s3_q.a0;
      end else if (s3_q.aidx == AI_END1) begin
        alpha_d = s3_q.a1;
      end else if (!s3_eight_q && s3_q.aidx == AI_ZERO) begin
        alpha_d = 8'd0;
      end else if (!s3_eight_q && s3_q.aidx == AI_FULL) begin
        alpha_d = 8'd255;
      end else begin
        alpha_d = s3_qa_q;
      end
    end else begin
      alpha_d = (s3_q.three && s3_q.ci == CI_MIX3) ? 8'd0 : 8'd255;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= pix_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      out_valid_o <= s3_v_q;
    end
  end

  // Payload, held on a stall
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q           <= pix_i;
      s2_q           <= s1_q;
      s2_eight_q     <= eight_d;
      s2_mean_q      <= mean_d;
      s2_numc_q      <= numc_d;
      s2_numa_q      <= numa_d;
      s3_q           <= s2_q;
      s3_eight_q     <= s2_eight_q;
      s3_mean_q      <= s2_mean_q;
      s3_qc_q        <= qc_d;
      s3_qa_q        <= proda[SHIFT57 +: 8];
      red_o          <= col_d[0];
      green_o        <= col_d[1];
      blue_o         <= col_d[2];
      alpha_o        <= alpha_d;
      pixel_column_o <= s3_q.k[1:0];
      pixel_row_o    <= s3_q.k[3:2];
      last_pixel_o   <= &s3_q.k;
    end
  end

endmodule

/* hdl/bc1_bc2_bc3_block_decoder.sv */
// Top level of the BC1/BC2/BC3 (DXT1/DXT3/DXT5) 4x4 block decoder.
// Depends on bcdec_pkg and bcdec_pixel_pipe.
//
// Each input transaction carries one compressed 16-byte block (colour half
// and alpha half); the block yields sixteen output transactions, one pixel
// each, in row-major order, the last flagged by last_pixel_o. The block is
// held in a block register and a 4-bit pixel counter walks it one pixel per
// cycle, unless the output stalls, into a four-stage pixel pipeline
// (numerators, reciprocal divide, palette select, output register), and
// the next block is accepted in the cycle its sixteenth pixel issues. A
// stall on the output freezes the whole pipeline; nothing is dropped or
// repeated. The block_format register (APB address 0) selects DXT1 (0),
// DXT3 (1) or DXT5 (2); code 3 decodes as DXT1. Write it only while the
// decoder is idle. RGB565 endpoints are widened by plain shifts, and all
// interpolation divides truncate.
module bc1_bc2_bc3_block_decoder import bcdec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Block input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] color_word_i,
  input  logic [63:0] alpha_word_i,
  // Pixel output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [1:0]  pixel_column_o,
  output logic [1:0]  pixel_row_o,
  output logic        last_pixel_o
);

  // Configuration register
  logic [1:0] fmt_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLOCK_FORMAT) ? {30'd0, fmt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_DXT1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BLOCK_FORMAT) begin
      fmt_q <= pwdata[1:0];
    end
  end

  // Block register and pixel counter
  logic        blk_valid_q;
  logic [3:0]  cnt_q;
  logic [63:0] color_q;
  logic [63:0] alpha_q;
  logic        adv;
  logic        issue;
  logic        last_issue;
  logic        accept;

  assign issue      = blk_valid_q && adv;
  assign last_issue = issue && (&cnt_q);
  // Take the next block in the cycle the last pixel of this one issues
  assign in_ready_o = !blk_valid_q || last_issue;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      cnt_q       <= 4'd0;
    end else begin
      if (accept) begin
        blk_valid_q <= 1'b1;
      end else if (last_issue) begin
        blk_valid_q <= 1'b0;
      end
      if (issue) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      color_q <= color_word_i;
      alpha_q <= alpha_word_i;
    end
  end

  // Pick out the current pixel's context
  pix_t       pix;
  logic [15:0] e0;
  logic [15:0] e1;
  logic        dxt3;
  logic        dxt5;
  logic [5:0]  aoff;

  always_comb begin
    e0   = color_q[15:0];
    e1   = color_q[31:16];
    dxt3 = fmt_q == FMT_DXT3;
    dxt5 = fmt_q == FMT_DXT5;
    aoff = {1'b0, cnt_q, 1'b0} + {2'b00, cnt_q};
    // Widen RGB565 by shifting only
    pix.c0    = {{e0[4:0], 3'b000}, {e0[10:5], 2'b00}, {e0[15:11], 3'b000}};
    pix.c1    = {{e1[4:0], 3'b000}, {e1[10:5], 2'b00}, {e1[15:11], 3'b000}};
    pix.ci    = color_q[32 + {cnt_q, 1'b0} +: 2];
    pix.three = !dxt3 && !dxt5 && !(e0 > e1);
    pix.dxt3  = dxt3;
    pix.dxt5  = dxt5;
    pix.a0    = alpha_q[7:0];
    pix.a1    = alpha_q[15:8];
    pix.aidx  = alpha_q[16 + aoff +: 3];
    pix.anib  = alpha_q[{cnt_q, 2'b00} +: 4];
    pix.k     = cnt_q;
  end

  bcdec_pixel_pipe u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_valid_i    (issue),
    .pix_i          (pix),
    .adv_o          (adv),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

/* dv/bc1_bc2_bc3_block_decoder_tb.sv */
// Self-checking testbench for the BC1/BC2/BC3 block decoder: drives compressed
// blocks, decodes them alongside in SystemVerilog and checks every pixel.
// Depends on bcdec_pkg and the bc1_bc2_bc3_block_decoder RTL.
module bc1_bc2_bc3_block_decoder_tb;
  import bcdec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Spare format code; the decoder treats it as DXT1
  localparam logic [1:0] FMT_SPARE = 2'd3;
  // Cycles with no transaction anywhere before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles to keep watching the output once nothing is expected
  localparam int unsigned TAIL_CYCLES = 20;
  // Every DXT1 colour index in turn (pixel k gets k mod 4)
  localparam logic [31:0] CI_SWEEP = 32'hE4E4_E4E4;
  // Every DXT5 alpha index in turn, twice (pixel k gets k mod 8)
  localparam logic [47:0] AI_SWEEP = 48'hFAC688_FAC688;
  // Every DXT3 nibble value once
  localparam logic [63:0] NIBBLE_SWEEP = 64'hFEDC_BA98_7654_3210;

  typedef struct {
    logic [63:0] cw;
    logic [63:0] aw;
  } block_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] column;
    logic [1:0] row;
    logic       last;
  } pixel_t;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_BURSTY} rx_mode_e;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [63:0] color_word_i   = '0;
  logic [63:0] alpha_word_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic [1:0]  pixel_column_o;
  logic [1:0]  pixel_row_o;
  logic        last_pixel_o;

  // Blocks waiting to be sent, and pixels waiting to come back
  block_t block_queue[$];
  pixel_t expected_pixels[$];

  // Shadow of the block_format register, updated at the write
  logic [1:0]  format_shadow = FMT_DXT1;

  int unsigned blocks_per_format[4];
  int unsigned pixels_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;

  // Sender burst state
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  // Receiver stall state
  rx_mode_e    rx_mode  = RX_FREE;
  int unsigned rx_span  = 0;
  int unsigned rx_run   = 0;
  logic        rx_level = 1'b1;

  bc1_bc2_bc3_block_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .color_word_i   (color_word_i),
    .alpha_word_i   (alpha_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .last_pixel_o   (last_pixel_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decode one block under the current format and queue its sixteen pixels.
  // Endpoints widen by plain shifts; every divide truncates.
  function automatic void decode_block(logic [63:0] cw, logic [63:0] aw);
    int unsigned pal [4][3];
    int unsigned apal [8];
    logic [15:0] e0;
    logic [15:0] e1;
    int unsigned a0, a1, ci, av, ch, i, k;
    logic        three, use_dxt3, use_dxt5;
    pixel_t      px;
    e0 = cw[15:0];
    e1 = cw[31:16];
    use_dxt3 = (format_shadow == FMT_DXT3);
    use_dxt5 = (format_shadow == FMT_DXT5);
    // Three-colour mode only in DXT1 (and the spare code) with e0 <= e1
    three = !use_dxt3 && !use_dxt5 && !(e0 > e1);
    pal[CI_END0][0] = {e0[15:11], 3'b000};
    pal[CI_END0][1] = {e0[10:5], 2'b00};
    pal[CI_END0][2] = {e0[4:0], 3'b000};
    pal[CI_END1][0] = {e1[15:11], 3'b000};
    pal[CI_END1][1] = {e1[10:5], 2'b00};
    pal[CI_END1][2] = {e1[4:0], 3'b000};
    for (ch = 0; ch < 3; ch++) begin
      if (three) begin
        pal[CI_MIX2][ch] = (pal[CI_END0][ch] + pal[CI_END1][ch]) / 2;
        pal[CI_MIX3][ch] = 0;
      end else begin
        pal[CI_MIX2][ch] = (2 * pal[CI_END0][ch] + pal[CI_END1][ch]) / 3;
        pal[CI_MIX3][ch] = (pal[CI_END0][ch] + 2 * pal[CI_END1][ch]) / 3;
      end
    end
    a0 = aw[7:0];
    a1 = aw[15:8];
    apal[AI_END0] = a0;
    apal[AI_END1] = a1;
    if (a0 > a1) begin
      for (i = 1; i < 7; i++) apal[i + 1] = ((7 - i) * a0 + i * a1) / 7;
    end else begin
      for (i = 1; i < 5; i++) apal[i + 1] = ((5 - i) * a0 + i * a1) / 5;
      apal[AI_ZERO] = 0;
      apal[AI_FULL] = 255;
    end
    for (k = 0; k < 16; k++) begin
      ci = cw[32 + 2 * k +: 2];
      if (use_dxt3) begin
        av = aw[4 * k +: 4] * 17;
      end else if (use_dxt5) begin
        av = apal[aw[16 + 3 * k +: 3]];
      end else begin
        av = (three && ci == CI_MIX3) ? 0 : 255;
      end
      px.red    = 8'(pal[ci][0]);
      px.green  = 8'(pal[ci][1]);
      px.blue   = 8'(pal[ci][2]);
      px.alpha  = 8'(av);
      px.column = k[1:0];
      px.row    = k[3:2];
      px.last   = (k == 15);
      expected_pixels.push_back(px);
    end
  endfunction

  function automatic void add_block(logic [63:0] cw, logic [63:0] aw);
    block_t b;
    b.cw = cw;
    b.aw = aw;
    block_queue.push_back(b);
  endfunction

  // Random block content, biased towards equal endpoints and edge values
  function automatic void add_random_block();
    logic [63:0] cw;
    logic [63:0] aw;
    cw = {$urandom, $urandom};
    aw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: cw[31:16] = cw[15:0];
      1: aw[15:8] = aw[7:0];
      2: cw[31:0] = $urandom_range(0, 1) ? 32'h0000_FFFF : 32'hFFFF_0000;
      3: aw[15:0] = $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
      4: cw[63:32] = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    add_block(cw, aw);
  endfunction

  // Hold until every queued block has gone and every pixel has come back
  task automatic wait_idle();
    while (block_queue.size() != 0 || expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  // APB write of block_format: setup cycle, then access cycle
  task automatic write_format(logic [1:0] fmt);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BLOCK_FORMAT, 2'b00};
    // Upper bits carry noise; only the low two bits belong to the register
    pwdata  <= {30'($urandom_range(0, 32'h3FFF_FFFF)), fmt};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    format_shadow = fmt;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Driver: present the head of block_queue in bursts with random gaps.
  // Decode each block at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_block(color_word_i, alpha_word_i);
        blocks_per_format[format_shadow]++;
        void'(block_queue.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // hold the transaction until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (block_queue.size() > 0) begin
        in_valid_i   <= 1'b1;
        color_word_i <= block_queue[0].cw;
        alpha_word_i <= block_queue[0].aw;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // a quarter of the bursts run straight on without a gap
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: take pixels, compare each with the oldest expectation, and
  // drive out_ready_i from a stall pattern that changes mode now and then.
  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {red_o, green_o, blue_o, alpha_o, pixel_column_o, pixel_row_o, last_pixel_o};
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: r%0d g%0d b%0d a%0d x%0d y%0d last %0d",
                   got.red, got.green, got.blue, got.alpha, got.column, got.row,
                   got.last);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.alpha !== want.alpha ||
            got.column !== want.column || got.row !== want.row ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel mismatch: expected r%0d g%0d b%0d a%0d x%0d y%0d last %0d,",
                     want.red, want.green, want.blue, want.alpha, want.column,
                     want.row, want.last);
            $display("                got      r%0d g%0d b%0d a%0d x%0d y%0d last %0d",
                     got.red, got.green, got.blue, got.alpha,
                     got.column, got.row, got.last);
          end
        end
      end
    end
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_span = $urandom_range(50, 300);
    end else begin
      rx_span--;
    end
    if (rx_run == 0) begin
      rx_level = !rx_level;
      rx_run   = $urandom_range(1, 12);
    end else begin
      rx_run--;
    end
    case (rx_mode)
      RX_FREE:   out_ready_i <= 1'b1;
      RX_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
      default:   out_ready_i <= rx_level;
    endcase
  end

  // Watchdog: any transaction or configuration access clears the count
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [1:0] random_formats [6];
    random_formats = '{FMT_DXT5, FMT_DXT1, FMT_SPARE, FMT_DXT3, FMT_DXT5, FMT_DXT1};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // DXT1: equal endpoints (three-colour), all-ones block with transparent
    // index 3, four-colour and three-colour sweeps, alpha half ignored
    write_format(FMT_DXT1);
    add_block(64'h0, 64'h0);
    add_block('1, '1);
    add_block({CI_SWEEP, 16'h0000, 16'hFFFF}, '1);
    add_block({CI_SWEEP, 16'hFFFF, 16'h0000}, 64'h0);
    add_block({CI_SWEEP, 16'h7BEF, 16'h8410}, {$urandom, $urandom});
    add_block({CI_SWEEP, 16'h8410, 16'h7BEF}, 64'h0);
    wait_idle();

    // DXT3: every nibble, extremes, and four colours despite e0 <= e1
    write_format(FMT_DXT3);
    add_block({CI_SWEEP, 16'hF81F, 16'h07E0}, NIBBLE_SWEEP);
    add_block({CI_SWEEP, 16'hFFFF, 16'hFFFF}, 64'h0);
    add_block('1, '1);
    add_block(64'h0, ~NIBBLE_SWEEP);
    wait_idle();

    // DXT5: eight- and six-level palettes, equal and extreme endpoints
    write_format(FMT_DXT5);
    add_block({CI_SWEEP, 16'h0000, 16'hFFFF}, {AI_SWEEP, 8'h00, 8'hFF});
    add_block({CI_SWEEP, 16'hFFFF, 16'h0000}, {AI_SWEEP, 8'hFF, 8'h00});
    add_block({CI_SWEEP, 16'h1234, 16'h1234}, {AI_SWEEP, 8'h80, 8'h80});
    add_block({CI_SWEEP, 16'hABCD, 16'h4321}, {AI_SWEEP, 8'h17, 8'hE9});
    add_block(64'h0, 64'h0);
    add_block('1, '1);
    wait_idle();

    // Spare code behaves as DXT1
    write_format(FMT_SPARE);
    add_block({CI_SWEEP, 16'hFFFF, 16'h0000}, NIBBLE_SWEEP);
    add_block({CI_SWEEP, 16'h0000, 16'hFFFF}, '1);
    wait_idle();

    // Random phases, format changed between them while idle
    foreach (random_formats[p]) begin
      write_format(random_formats[p]);
      repeat (35) add_random_block();
      // drain everything once before the second half of the first phase
      if (p == 0) wait_idle();
      repeat (35) add_random_block();
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Decoded %0d DXT1, %0d DXT3, %0d DXT5 and %0d spare-code blocks, %0d pixels",
             blocks_per_format[FMT_DXT1], blocks_per_format[FMT_DXT3],
             blocks_per_format[FMT_DXT5], blocks_per_format[FMT_SPARE], pixels_checked);
    $display("under bursty input, output stalls and format changes; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bcdec_pkg.sv
hdl/bcdec_pixel_pipe.sv
hdl/bc1_bc2_bc3_block_decoder.sv
dv/bc1_bc2_bc3_block_decoder_tb.sv
